// File: design/kmw_pkg.sv
// shared types and constants for the kruskal spanning tree weight unit
package kmw_pkg;

	localparam int RANK_BITS = 4;
	localparam logic [RANK_BITS-1:0] RANK_MAX = 4'd15;
	localparam int SUM_BITS = 24;
	localparam int CNT_BITS = 8;
	localparam int CFG_BITS = 9;
	localparam logic [CFG_BITS-1:0] NODE_COUNT_RESET = 9'd256;

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_SORT     = 8'b0000_0010,
		S_SORT_END = 8'b0000_0100,
		S_INIT     = 8'b0000_1000,
		S_K_RD     = 8'b0001_0000,
		S_K_EDGE   = 8'b0010_0000,
		S_K_WAIT   = 8'b0100_0000,
		S_DONE     = 8'b1000_0000
	} kmw_state_t;

	typedef enum logic [4:0] {
		U_IDLE = 5'b00001,
		U_INIT = 5'b00010,
		U_FA   = 5'b00100,
		U_FB   = 5'b01000,
		U_RANK = 5'b10000
	} kmw_uf_state_t;

	typedef struct packed {
		logic init;
		logic query;
	} kmw_uf_cmd_t;

	typedef struct packed {
		logic done;
		logic joined;
	} kmw_uf_stat_t;

endpackage

// File: design/kmw_ram.sv
// generic single write port ram with registered read
module kmw_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  logic [WIDTH-1:0]      wdata,
	input  logic                  re,
	input  logic [AW-1:0]         raddr,
	output logic [WIDTH-1:0]      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// File: design/kmw_uf.sv
// union-find engine: parent and rank table in one ram, root walks and joins by rank
module kmw_uf #(
	parameter int MAX_NODES = 256,
	localparam int NB = $clog2(MAX_NODES)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  kmw_pkg::kmw_uf_cmd_t   cmd,
	input  logic [NB:0]            node_total,
	input  logic [NB-1:0]          node_a,
	input  logic [NB-1:0]          node_b,
	output kmw_pkg::kmw_uf_stat_t  stat
);
	localparam int PW = kmw_pkg::RANK_BITS + NB;

	kmw_pkg::kmw_uf_state_t st_q;
	logic [NB-1:0] x_q, b_q, ru_q;
	logic [kmw_pkg::RANK_BITS-1:0] rku_q;
	logic [NB:0] i_q, n_q;
	logic done_q, joined_q;

	logic we, re;
	logic [NB-1:0] waddr, raddr;
	logic [PW-1:0] wdata, rdata;
	logic [NB-1:0] par;
	logic [kmw_pkg::RANK_BITS-1:0] rk;

	assign par = rdata[NB-1:0];
	assign rk = rdata[PW-1:NB];

	kmw_ram #(.WIDTH(PW), .DEPTH(MAX_NODES)) u_tbl (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.re(re), .raddr(raddr), .rdata(rdata)
	);

	always_comb begin
		we = 1'b0;
		waddr = i_q[NB-1:0];
		wdata = {{kmw_pkg::RANK_BITS{1'b0}}, i_q[NB-1:0]};
		re = 1'b0;
		raddr = node_a;
		unique case (st_q)
			kmw_pkg::U_IDLE: begin
				re = cmd.query;
			end
			kmw_pkg::U_INIT: begin
				we = 1'b1;
			end
			kmw_pkg::U_FA: begin
				re = 1'b1;
				raddr = (par == x_q) ? b_q : par;
			end
			kmw_pkg::U_FB: begin
				if (par != x_q) begin
					re = 1'b1;
					raddr = par;
				end else if (par != ru_q) begin
					we = 1'b1;
					if (rku_q < rk) begin
						waddr = ru_q;
						wdata = {rku_q, par};
					end else begin
						waddr = par;
						wdata = {rk, ru_q};
					end
				end
			end
			kmw_pkg::U_RANK: begin
				we = 1'b1;
				waddr = ru_q;
				wdata = {(rku_q == kmw_pkg::RANK_MAX) ? rku_q : rku_q + 1'b1, ru_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= kmw_pkg::U_IDLE;
			done_q <= 1'b0;
			joined_q <= 1'b0;
			i_q <= '0;
			n_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				kmw_pkg::U_IDLE: begin
					if (cmd.init) begin
						i_q <= '0;
						n_q <= node_total;
						if (node_total == '0) begin
							done_q <= 1'b1;
						end else begin
							st_q <= kmw_pkg::U_INIT;
						end
					end else if (cmd.query) begin
						st_q <= kmw_pkg::U_FA;
					end
				end
				kmw_pkg::U_INIT: begin
					i_q <= i_q + 1'b1;
					if (i_q + 1'b1 == n_q) begin
						done_q <= 1'b1;
						st_q <= kmw_pkg::U_IDLE;
					end
				end
				kmw_pkg::U_FA: begin
					if (par == x_q) begin
						st_q <= kmw_pkg::U_FB;
					end
				end
				kmw_pkg::U_FB: begin
					if (par == x_q) begin
						joined_q <= (par != ru_q);
						if (par != ru_q && rku_q == rk) begin
							st_q <= kmw_pkg::U_RANK;
						end else begin
							done_q <= 1'b1;
							st_q <= kmw_pkg::U_IDLE;
						end
					end
				end
				kmw_pkg::U_RANK: begin
					done_q <= 1'b1;
					st_q <= kmw_pkg::U_IDLE;
				end
				default: st_q <= kmw_pkg::U_IDLE;
			endcase
		end
	end

	// walk pointer and latched endpoints
	always_ff @(posedge clk) begin
		unique case (st_q)
			kmw_pkg::U_IDLE: begin
				x_q <= node_a;
				b_q <= node_b;
			end
			kmw_pkg::U_FA: begin
				if (par == x_q) begin
					ru_q <= x_q;
					rku_q <= rk;
					x_q <= b_q;
				end else begin
					x_q <= par;
				end
			end
			kmw_pkg::U_FB: begin
				if (par != x_q) begin
					x_q <= par;
				end
			end
			default: ;
		endcase
	end

	assign stat.done = done_q;
	assign stat.joined = joined_q;

	a_init_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == kmw_pkg::U_INIT) |-> (i_q < n_q))
		else $error("init sweep ran past node count");
	a_rank_after_join: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == kmw_pkg::U_RANK) |=> (done_q && joined_q))
		else $error("rank bump without join report");
endmodule

// File: design/kruskal_mst_weight_unit.sv
// top level: edge loading, in-memory bubble sort and kruskal edge walk
// load: one edge transfer per cycle while busy is low; after the last edge the store is bubble
// sorted by weight until a pass makes no swap, then table init covers node_count entries (clamped).
// each edge is then skipped with an end out of range, else both root walks run and the roots join by rank,
// with a rank bump for an equal-rank join; one result strobe, receiver cannot stall, busy falls after.
// arst_n clears control state and sets node_count to 256; the rams are not cleared.
module kruskal_mst_weight_unit #(
	parameter int MAX_NODES = 256,
	parameter int MAX_EDGES = 1024,
	parameter int WEIGHT_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [7:0]          node_a,
	input  logic [7:0]          node_b,
	input  logic signed [15:0]  edge_weight,
	input  logic                last_edge,
	input  logic                cfg_we,
	input  logic [8:0]          cfg_wdata,
	output logic                result_valid,
	output logic signed [23:0]  total_weight,
	output logic [7:0]          tree_edges
);
	localparam int NB = $clog2(MAX_NODES);
	localparam int NCW = NB + 1;
	localparam int AB = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int EB = $clog2(MAX_EDGES + 1);
	localparam int EW = 16 + WEIGHT_BITS;
	localparam logic [EB-1:0] EDGE_CAP = EB'(MAX_EDGES);

	kmw_pkg::kmw_state_t state_q;
	logic [8:0] node_count_q;
	logic [EB-1:0] fill_q, rptr_q, k_q, fill_m1;
	logic rvalid_s1;
	logic [AB-1:0] ridx_s1;
	logic [EW-1:0] carry_q;
	logic swapped_q;
	logic signed [WEIGHT_BITS-1:0] w_q;
	logic [kmw_pkg::SUM_BITS-1:0] sum_q;
	logic [kmw_pkg::CNT_BITS-1:0] cnt_q;

	logic we, re;
	logic [AB-1:0] waddr, raddr;
	logic [EW-1:0] wdata, rdata;
	logic signed [31:0] w_ext;
	logic [7:0] rd_a, rd_b;
	logic signed [WEIGHT_BITS-1:0] rd_w, carry_w;
	logic [NCW-1:0] node_lim;
	logic in_range, take, last_k, sort_last, carry_gt;
	kmw_pkg::kmw_uf_cmd_t uf_cmd;
	kmw_pkg::kmw_uf_stat_t uf_stat;

	assign w_ext = 32'(edge_weight);
	assign rd_a = rdata[EW-1:EW-8];
	assign rd_b = rdata[EW-9:EW-16];
	assign rd_w = rdata[WEIGHT_BITS-1:0];
	assign carry_w = carry_q[WEIGHT_BITS-1:0];
	assign carry_gt = carry_w > rd_w;
	assign node_lim = (32'(node_count_q) > MAX_NODES) ? NCW'(MAX_NODES) : NCW'(node_count_q);
	assign in_range = (32'(rd_a) < 32'(node_lim)) && (32'(rd_b) < 32'(node_lim));
	assign fill_m1 = fill_q - 1'b1;
	assign take = start && !busy;
	assign last_k = (k_q == fill_m1);
	assign sort_last = rvalid_s1 && (EB'(ridx_s1) == fill_m1);
	assign busy = (state_q != kmw_pkg::S_IDLE);

	kmw_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edges (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.re(re), .raddr(raddr), .rdata(rdata)
	);

	kmw_uf #(.MAX_NODES(MAX_NODES)) u_uf (
		.clk(clk), .arst_n(arst_n), .cmd(uf_cmd), .node_total(node_lim),
		.node_a(NB'(rd_a)), .node_b(NB'(rd_b)), .stat(uf_stat)
	);

	always_comb begin
		we = 1'b0;
		waddr = fill_q[AB-1:0];
		wdata = {node_a, node_b, w_ext[WEIGHT_BITS-1:0]};
		re = 1'b0;
		raddr = rptr_q[AB-1:0];
		uf_cmd.init = 1'b0;
		uf_cmd.query = 1'b0;
		unique case (state_q)
			kmw_pkg::S_IDLE: begin
				we = take && (fill_q < EDGE_CAP);
			end
			kmw_pkg::S_SORT: begin
				re = (rptr_q < fill_q);
				// bubble pass: smaller of carry and fetched entry drops one slot back
				if (rvalid_s1 && ridx_s1 != '0) begin
					we = 1'b1;
					waddr = ridx_s1 - 1'b1;
					wdata = carry_gt ? rdata : carry_q;
				end
			end
			kmw_pkg::S_SORT_END: begin
				we = 1'b1;
				waddr = fill_m1[AB-1:0];
				wdata = carry_q;
				uf_cmd.init = !swapped_q;
			end
			kmw_pkg::S_K_RD: begin
				re = 1'b1;
				raddr = k_q[AB-1:0];
			end
			kmw_pkg::S_K_EDGE: begin
				uf_cmd.query = in_range;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kmw_pkg::S_IDLE;
			node_count_q <= kmw_pkg::NODE_COUNT_RESET;
			fill_q <= '0;
			rptr_q <= '0;
			k_q <= '0;
			rvalid_s1 <= 1'b0;
			swapped_q <= 1'b0;
			sum_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				node_count_q <= cfg_wdata;
			end
			rvalid_s1 <= (state_q == kmw_pkg::S_SORT) && (rptr_q < fill_q);
			unique case (state_q)
				kmw_pkg::S_IDLE: begin
					if (take) begin
						if (fill_q < EDGE_CAP) begin
							fill_q <= fill_q + 1'b1;
						end
						if (last_edge) begin
							rptr_q <= '0;
							swapped_q <= 1'b0;
							state_q <= kmw_pkg::S_SORT;
						end
					end
				end
				kmw_pkg::S_SORT: begin
					if (rptr_q < fill_q) begin
						rptr_q <= rptr_q + 1'b1;
					end
					if (rvalid_s1 && ridx_s1 != '0 && carry_gt) begin
						swapped_q <= 1'b1;
					end
					if (sort_last) begin
						state_q <= kmw_pkg::S_SORT_END;
					end
				end
				kmw_pkg::S_SORT_END: begin
					rptr_q <= '0;
					swapped_q <= 1'b0;
					sum_q <= '0;
					cnt_q <= '0;
					k_q <= '0;
					state_q <= swapped_q ? kmw_pkg::S_SORT : kmw_pkg::S_INIT;
				end
				kmw_pkg::S_INIT: begin
					if (uf_stat.done) begin
						state_q <= kmw_pkg::S_K_RD;
					end
				end
				kmw_pkg::S_K_RD: begin
					state_q <= kmw_pkg::S_K_EDGE;
				end
				kmw_pkg::S_K_EDGE: begin
					if (in_range) begin
						state_q <= kmw_pkg::S_K_WAIT;
					end else begin
						k_q <= k_q + 1'b1;
						state_q <= last_k ? kmw_pkg::S_DONE : kmw_pkg::S_K_RD;
					end
				end
				kmw_pkg::S_K_WAIT: begin
					if (uf_stat.done) begin
						if (uf_stat.joined) begin
							sum_q <= sum_q + kmw_pkg::SUM_BITS'(w_q);
							cnt_q <= cnt_q + 1'b1;
						end
						k_q <= k_q + 1'b1;
						state_q <= last_k ? kmw_pkg::S_DONE : kmw_pkg::S_K_RD;
					end
				end
				kmw_pkg::S_DONE: begin
					fill_q <= '0;
					state_q <= kmw_pkg::S_IDLE;
				end
				default: state_q <= kmw_pkg::S_IDLE;
			endcase
		end
	end

	// sort carry and edge payload
	always_ff @(posedge clk) begin
		ridx_s1 <= rptr_q[AB-1:0];
		if (state_q == kmw_pkg::S_SORT && rvalid_s1) begin
			if (ridx_s1 == '0 || !carry_gt) begin
				carry_q <= rdata;
			end
		end
		if (state_q == kmw_pkg::S_K_EDGE) begin
			w_q <= rd_w;
		end
	end

	assign result_valid = (state_q == kmw_pkg::S_DONE);
	assign total_weight = sum_q;
	assign tree_edges = cnt_q;

	a_result_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !busy)
		else $error("busy held after result");
	a_uf_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		uf_stat.done |-> (state_q == kmw_pkg::S_INIT || state_q == kmw_pkg::S_K_WAIT))
		else $error("union-find reply with no request pending");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= EDGE_CAP)
		else $error("edge fill beyond capacity");
	a_sort_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == kmw_pkg::S_SORT && rvalid_s1) |-> (EB'(ridx_s1) < fill_q))
		else $error("sort fetched past last edge");
endmodule

// File: test/tb_top.sv
// self-checking testbench for the kruskal spanning tree weight unit
module tb_top;

	localparam int EDGE_CAP = 1024;
	localparam int NODE_CAP = 256;
	localparam int RANDOM_EDGES = 800;
	// the sort of a full store makes no transfer while it runs
	localparam int IDLE_LIMIT = 3000000;

	typedef struct {
		logic [7:0] a;
		logic [7:0] b;
		logic signed [15:0] w;
	} edge_rec_t;

	typedef struct {
		logic signed [kmw_pkg::SUM_BITS-1:0] sum;
		logic [kmw_pkg::CNT_BITS-1:0] cnt;
	} forest_t;

	class forest_scoreboard;
		edge_rec_t stored[$];
		forest_t awaited[$];
		logic [kmw_pkg::CFG_BITS-1:0] nodes_in_use = kmw_pkg::NODE_COUNT_RESET;
		int errors = 0;
		int graphs = 0;
		int checked = 0;

		task report(input string what);
			errors++;
			$display("error at %0t: %s", $realtime, what);
		endtask

		function int find_root(ref int par[NODE_CAP], input int x);
			int r;
			int nxt;
			r = x;
			while (par[r] != r) r = par[r];
			while (x != r) begin
				nxt = par[x];
				par[x] = r;
				x = nxt;
			end
			return r;
		endfunction

		function void spanning_forest();
			edge_rec_t ord[$];
			edge_rec_t e;
			int par[NODE_CAP];
			int rnk[NODE_CAP];
			int n;
			int j;
			int ra;
			int rb;
			forest_t f;
			ord = stored;
			// stable insertion sort by weight
			for (int i = 1; i < ord.size(); i++) begin
				e = ord[i];
				j = i;
				while (j > 0 && ord[j-1].w > e.w) begin
					ord[j] = ord[j-1];
					j--;
				end
				ord[j] = e;
			end
			n = (nodes_in_use > NODE_CAP) ? NODE_CAP : int'(nodes_in_use);
			for (int i = 0; i < NODE_CAP; i++) begin
				par[i] = i;
				rnk[i] = 0;
			end
			f.sum = '0;
			f.cnt = '0;
			foreach (ord[i]) begin
				if (ord[i].a >= n || ord[i].b >= n) continue;
				ra = find_root(par, ord[i].a);
				rb = find_root(par, ord[i].b);
				if (ra == rb) continue;
				f.sum = f.sum + kmw_pkg::SUM_BITS'(ord[i].w);
				f.cnt = f.cnt + 1'b1;
				if (rnk[ra] < rnk[rb]) begin
					par[ra] = rb;
				end else if (rnk[ra] > rnk[rb]) begin
					par[rb] = ra;
				end else begin
					par[rb] = ra;
					if (rnk[ra] < kmw_pkg::RANK_MAX) rnk[ra]++;
				end
			end
			awaited.push_back(f);
			graphs++;
			stored.delete();
		endfunction

		function void note_edge(input edge_rec_t e, input logic lst);
			if (stored.size() < EDGE_CAP) stored.push_back(e);
			if (lst) spanning_forest();
		endfunction

		task check_result(input logic signed [kmw_pkg::SUM_BITS-1:0] sum,
				input logic [kmw_pkg::CNT_BITS-1:0] cnt);
			forest_t f;
			if (awaited.size() == 0) begin
				report($sformatf("unexpected result %0d/%0d", sum, cnt));
			end else begin
				f = awaited.pop_front();
				checked++;
				if (sum !== f.sum)
					report($sformatf("total_weight %0d, want %0d", sum, f.sum));
				if (cnt !== f.cnt)
					report($sformatf("tree_edges %0d, want %0d", cnt, f.cnt));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [7:0] node_a = '0;
	logic [7:0] node_b = '0;
	logic signed [15:0] edge_weight = '0;
	logic last_edge = 1'b0;
	logic cfg_we = 1'b0;
	logic [8:0] cfg_wdata = '0;
	logic result_valid;
	logic signed [23:0] total_weight;
	logic [7:0] tree_edges;

	forest_scoreboard sb = new();
	int idle_cycles = 0;
	int burst_left = 0;
	int edges_sent = 0;

	always #5 clk = ~clk;

	kruskal_mst_weight_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.node_a(node_a),
		.node_b(node_b),
		.edge_weight(edge_weight),
		.last_edge(last_edge),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.result_valid(result_valid),
		.total_weight(total_weight),
		.tree_edges(tree_edges)
	);

	always @(posedge clk) begin
		if (result_valid) begin
			sb.check_result(total_weight, tree_edges);
		end
		if (result_valid || (start && !busy)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		wait (idle_cycles >= IDLE_LIMIT);
		$display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
		$display("kruskal_mst_weight_unit: mismatch");
		$finish;
	end

	task automatic send_edge(input logic [7:0] a, input logic [7:0] b,
			input logic signed [15:0] w, input logic lst, input bit no_gap = 0);
		edge_rec_t e;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if (!no_gap) repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		burst_left--;
		start = 1'b1;
		node_a = a;
		node_b = b;
		edge_weight = w;
		last_edge = lst;
		do @(posedge clk); while (busy);
		e.a = a;
		e.b = b;
		e.w = w;
		sb.note_edge(e, lst);
		edges_sent++;
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic drain();
		wait (sb.awaited.size() == 0);
		// busy drops the cycle after the strobe
		repeat (4) @(negedge clk);
	endtask

	task automatic write_node_count(input logic [8:0] v);
		drain();
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.nodes_in_use = v;
	endtask

	task automatic random_graph(input int n_edges);
		int span;
		logic [7:0] a;
		logic [7:0] b;
		span = (sb.nodes_in_use == 0) ? 1
			: (sb.nodes_in_use > NODE_CAP ? NODE_CAP : int'(sb.nodes_in_use));
		for (int i = 0; i < n_edges; i++) begin
			// mostly in-range endpoints, some anywhere
			if ($urandom_range(0, 9) == 0) begin
				a = 8'($urandom);
				b = 8'($urandom);
			end else begin
				a = 8'($urandom_range(0, span - 1));
				b = 8'($urandom_range(0, span - 1));
			end
			send_edge(a, b, ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 4))
				: 16'($urandom), i == n_edges - 1);
		end
	endtask

	initial begin
		logic [8:0] counts[8];
		counts = '{9'd1, 9'd2, 9'd256, 9'd0, 9'd511, 9'd300, 9'd5, 9'd16};
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// reset node count, extremes of weight and index, self loop, duplicate
		send_edge(8'd0, 8'd255, 16'sh7fff, 1'b0);
		send_edge(8'd255, 8'd0, -16'sh8000, 1'b0);
		send_edge(8'd3, 8'd3, 16'sd100, 1'b0);
		send_edge(8'd0, 8'd255, 16'sd7, 1'b0);
		send_edge(8'd1, 8'd2, -16'sd1, 1'b1);
		write_node_count(9'd2);
		send_edge(8'd0, 8'd1, 16'sd5, 1'b0);
		send_edge(8'd0, 8'd2, 16'sd1, 1'b0);
		send_edge(8'd1, 8'd0, -16'sd1, 1'b1);
		write_node_count(9'd0);
		send_edge(8'd0, 8'd0, 16'sd1, 1'b1);
		write_node_count(9'd1);
		send_edge(8'd0, 8'd0, 16'sd7, 1'b0);
		send_edge(8'd0, 8'd1, 16'sd9, 1'b1);
		write_node_count(9'd511);
		send_edge(8'd10, 8'd20, 16'sd3, 1'b0);
		send_edge(8'd20, 8'd255, 16'sd4, 1'b1);
		// a full chain gives the largest edge count
		write_node_count(9'd256);
		for (int i = 0; i < 255; i++)
			send_edge(8'(i), 8'(i + 1), -16'sh8000, i == 254, 1'b1);

		while (edges_sent < RANDOM_EDGES) begin
			if ($urandom_range(0, 3) == 0) write_node_count(counts[$urandom_range(0, 7)]);
			else if ($urandom_range(0, 5) == 0)
				write_node_count(9'($urandom_range(0, 511)));
			if ($urandom_range(0, 7) == 0) drain();
			random_graph($urandom_range(0, 9) == 0 ? $urandom_range(25, 64)
				: $urandom_range(1, 24));
		end

		// overfull store: equal weights keep the sort short, last mark on a dropped edge
		write_node_count(9'd256);
		for (int i = 0; i < EDGE_CAP + 6; i++)
			send_edge(8'($urandom), 8'($urandom), 16'sd3, i == EDGE_CAP + 5);

		drain();
		repeat (20) @(negedge clk);
		$display("graphs: %0d, edges sent: %0d, results checked: %0d",
			sb.graphs, edges_sent, sb.checked);
		$display("covered node counts 0..511, self loops, out-of-range ends, full store");
		if (sb.errors == 0 && sb.awaited.size() == 0) begin
			$display("kruskal_mst_weight_unit: match");
		end else begin
			$display("kruskal_mst_weight_unit: mismatch");
		end
		$finish;
	end

endmodule

// File: kruskal_mst_weight_unit.f
design/kmw_pkg.sv
design/kmw_ram.sv
design/kmw_uf.sv
design/kruskal_mst_weight_unit.sv
test/tb_top.sv
